### rtl/efsd_pkg.sv
`timescale 1ns / 1ps
// Package for the escaped frame stream decoder: constants, result kind codes,
// controller states and the command/status structs. No dependencies.
package efsd_pkg;

   localparam logic [7:0] MARK         = 8'hF0;
   localparam logic [7:0] LEN_BIAS     = 8'd32;
   localparam int         STORE_DEPTH  = 225;
   localparam int         STORE_AW     = 8;
   localparam logic [4:0] INIT_LEN     = 5'd21;
   localparam logic [4:0] MARKS_NEEDED = 5'd6;
   localparam logic [2:0] RUN_MAX      = 3'd6;
   localparam int         TAIL_BITS    = 196;

   localparam logic [1:0] KIND_PASS = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_CMD  = 2'd2;
   localparam logic [1:0] KIND_INIT = 2'd3;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_PASS,
      EMIT_INIT,
      EMIT_FRAME
   } emit_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PASS,
      ST_ALIGN,
      ST_READ,
      ST_GATHER,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic     capture;
      logic     step;
      logic     align;
      logic     rd_issue;
      logic     gather;
      emit_type emit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic in_frame;
      logic quoted;
      logic frame_end;
      logic init_hit;
      logic frame_start;
      logic no_data;
      logic frame_ready;
      logic frame_last;
   } dp_stat_type;

   // Characters of the init sequence: six markers, then the text.
   function automatic logic [7:0] init_char(input logic [4:0] pos);
      logic [7:0] ch;
      unique case (pos) inside
         [5'd0:5'd5]: ch = MARK;
         5'd6:  ch = 8'h53;
         5'd7:  ch = 8'h68;
         5'd8:  ch = 8'h65;
         5'd9:  ch = 8'h6C;
         5'd10: ch = 8'h6C;
         5'd11: ch = 8'h54;
         5'd12: ch = 8'h75;
         5'd13: ch = 8'h6E;
         5'd14: ch = 8'h6E;
         5'd15: ch = 8'h65;
         5'd16: ch = 8'h6C;
         5'd17: ch = 8'h49;
         5'd18: ch = 8'h6E;
         5'd19: ch = 8'h69;
         5'd20: ch = 8'h74;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### rtl/efsd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module efsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 225
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/efsd_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the decoder: sequences byte decode and frame unpack.
// Depends on efsd_pkg.
module efsd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  efsd_pkg::dp_stat_type stat,
   output efsd_pkg::dp_cmd_type  cmd
);
   import efsd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.emit  = EMIT_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.out_free) begin
               cmd.step = 1'b1;
               if (stat.in_frame) begin
                  if (stat.quoted) begin
                     cmd.emit = EMIT_PASS;
                     state_in = ST_IDLE;
                  end else if (stat.frame_end) begin
                     state_in = ST_ALIGN;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else if (stat.init_hit) begin
                  cmd.emit = EMIT_INIT;
                  state_in = ST_PASS;
               end else if (stat.frame_start) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit = EMIT_PASS;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PASS: begin
            if (stat.out_free) begin
               cmd.emit = EMIT_PASS;
               state_in = ST_IDLE;
            end
         end
         ST_ALIGN: begin
            cmd.align = 1'b1;
            state_in  = stat.no_data ? ST_IDLE : ST_READ;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_GATHER;
         end
         ST_GATHER: begin
            cmd.gather = 1'b1;
            state_in   = stat.frame_ready ? ST_EMIT : ST_READ;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = EMIT_FRAME;
               state_in = stat.frame_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/efsd_dp.sv
`timescale 1ns / 1ps
// Datapath of the decoder: stream state, frame store, tail bit stack, result register.
// Depends on efsd_pkg and efsd_ram.
module efsd_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_in_byte,
   input  logic                  csr_valid,
   input  logic                  csr_role_is_client,
   input  efsd_pkg::dp_cmd_type  cmd,
   output efsd_pkg::dp_stat_type stat,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_byte0,
   output logic [7:0]            rsp_byte1,
   output logic [7:0]            rsp_byte2,
   output logic [7:0]            rsp_byte3,
   output logic [2:0]            rsp_valid_bytes,
   output logic [7:0]            rsp_channel,
   output logic [7:0]            rsp_command_type,
   output logic [15:0]           rsp_port,
   output logic                  rsp_last
);
   import efsd_pkg::*;

   // Control state.
   logic       role_ff, role_in;
   logic       done_ff, done_in;
   logic [4:0] pos_ff, pos_in;
   logic [2:0] run_ff, run_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] expected_ff, expected_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [7:0]           byte_ff, byte_in;
   logic [7:0]           l_ff, l_in;
   logic [4:0]           tail_ff, tail_in;
   logic                 is_cmd_ff, is_cmd_in;
   logic [TAIL_BITS-1:0] bits_ff, bits_in;
   logic [7:0]           j_ff, j_in;
   logic [7:0]           chan_ff, chan_in;
   logic [7:0]           ctype_ff, ctype_in;
   logic [15:0]          port_ff, port_in;
   logic [3:0][7:0]      word_ff, word_in;
   logic [2:0]           vcnt_ff, vcnt_in;
   logic                 plast_ff, plast_in;

   logic [1:0]  o_kind;
   logic [3:0][7:0] o_word;
   logic [2:0]  o_vcnt;
   logic [7:0]  o_chan, o_ctype;
   logic [15:0] o_port;
   logic        o_last;
   logic [1:0]  kind_ff;
   logic [3:0][7:0] oword_ff;
   logic [2:0]  ovcnt_ff;
   logic [7:0]  ochan_ff, octype_ff;
   logic [15:0] oport_ff;
   logic        olast_ff;

   // Decode helpers.
   logic       in_frame, text_hit, init_hit, done1, frame_start, quoted, frame_end;
   logic       push;
   logic [4:0] pos1, pos2;
   logic [2:0] run1;
   logic [7:0] n_val, len_val, excess;
   logic [8:0] len_p7;
   logic [6:0] rev7;
   logic [7:0] rd_data, gbyte, jm1;
   logic [1:0] slot;
   logic       data_last;

   efsd_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.step && in_frame),
      .wr_addr (count_ff),
      .wr_data (byte_ff),
      .rd_en   (cmd.rd_issue),
      .rd_addr (j_ff + 8'd2),
      .rd_data (rd_data)
   );

   assign in_frame = (count_ff != 8'd0);

   always_comb begin
      text_hit = (pos_ff < INIT_LEN) && (byte_ff == init_char(pos_ff));
      init_hit = 1'b0;
      pos1     = pos_ff;
      if (role_ff && (pos_ff >= MARKS_NEEDED)) begin
         if (text_hit) begin
            if (pos_ff == INIT_LEN - 5'd1) begin
               init_hit = 1'b1;
               pos1     = 5'd0;
            end else begin
               pos1 = pos_ff + 5'd1;
            end
         end else begin
            pos1 = 5'd0;
         end
      end
      done1 = done_ff | init_hit;
      if (byte_ff == MARK) begin
         run1 = (run_ff < RUN_MAX) ? run_ff + 3'd1 : run_ff;
         pos2 = (run1 >= RUN_MAX) ? MARKS_NEEDED : pos1;
      end else begin
         run1 = 3'd0;
         pos2 = pos1;
      end
      frame_start = (byte_ff == MARK) && done1;

      n_val   = (byte_ff >= LEN_BIAS) ? byte_ff - LEN_BIAS : 8'd0;
      len_val = (n_val == 8'd0) ? 8'd5 : n_val;
      len_p7  = {1'b0, len_val} + 9'd7;
      quoted  = in_frame && (count_ff == 8'd1) && (n_val == 8'd1);
      frame_end = in_frame && (count_ff != 8'd1)
                  && (({1'b0, count_ff} + 9'd1) >= {1'b0, expected_ff});
      push    = ({1'b0, count_ff} >= ({1'b0, l_ff} + 9'd2));
      for (int i = 0; i < 7; i++) begin
         rev7[6-i] = byte_ff[i];
      end
      excess  = ({3'b000, tail_ff} << 3) - {3'b000, tail_ff} - l_ff;

      gbyte     = {bits_ff[0], rd_data[6:0]};
      jm1       = j_ff - 8'd1;
      slot      = jm1[1:0];
      data_last = (({1'b0, j_ff} + 9'd1) == {1'b0, l_ff});
   end

   always_comb begin
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
      stat.in_frame    = in_frame;
      stat.quoted      = quoted;
      stat.frame_end   = frame_end;
      stat.init_hit    = init_hit;
      stat.frame_start = frame_start;
      stat.no_data     = !is_cmd_ff && (l_ff < 8'd2);
      stat.frame_ready = is_cmd_ff ? (j_ff == 8'd3)
                         : ((j_ff != 8'd0) && ((slot == 2'd3) || data_last));
      stat.frame_last  = plast_ff;
   end

   always_comb begin
      role_in     = role_ff;
      done_in     = done_ff;
      pos_in      = pos_ff;
      run_in      = run_ff;
      count_in    = count_ff;
      expected_in = expected_ff;
      byte_in     = byte_ff;
      l_in        = l_ff;
      tail_in     = tail_ff;
      is_cmd_in   = is_cmd_ff;
      bits_in     = bits_ff;
      j_in        = j_ff;
      chan_in     = chan_ff;
      ctype_in    = ctype_ff;
      port_in     = port_ff;
      word_in     = word_ff;
      vcnt_in     = vcnt_ff;
      plast_in    = plast_ff;

      if (cmd.capture) begin
         byte_in = req_in_byte;
      end

      if (cmd.step) begin
         if (in_frame) begin
            if (count_ff == 8'd1) begin
               if (quoted) begin
                  count_in = 8'd0;
               end else begin
                  count_in    = 8'd2;
                  expected_in = (n_val == 8'd0) ? 8'd7 : n_val + 8'd2;
                  tail_in     = len_p7[7:3];
                  l_in        = len_val - {3'b000, len_p7[7:3]};
                  is_cmd_in   = (byte_ff == LEN_BIAS);
               end
            end else begin
               count_in = frame_end ? 8'd0 : count_ff + 8'd1;
               if (push) begin
                  bits_in = {bits_ff[TAIL_BITS-8:0], rev7};
               end
            end
         end else begin
            pos_in  = pos2;
            run_in  = run1;
            done_in = done1;
            if (frame_start) begin
               count_in    = 8'd1;
               expected_in = 8'd2;
            end
         end
      end

      if (cmd.align) begin
         bits_in = bits_ff >> excess[2:0];
         j_in    = 8'd0;
      end

      if (cmd.gather) begin
         bits_in = bits_ff >> 1;
         j_in    = j_ff + 8'd1;
         if (is_cmd_ff) begin
            plast_in = 1'b1;
            case (j_ff[1:0])
               2'd0:    ctype_in       = gbyte;
               2'd1:    chan_in        = gbyte;
               2'd2:    port_in[15:8]  = gbyte;
               default: port_in[7:0]   = gbyte;
            endcase
         end else begin
            plast_in = data_last;
            if (j_ff == 8'd0) begin
               chan_in = gbyte;
            end else begin
               if (slot == 2'd0) begin
                  word_in = '0;
               end
               word_in[slot] = gbyte;
               vcnt_in       = {1'b0, slot} + 3'd1;
            end
         end
      end

      if (csr_valid) begin
         role_in = csr_role_is_client;
         done_in = !csr_role_is_client;
      end
   end

   // Result selection.
   always_comb begin
      o_kind  = KIND_PASS;
      o_word  = '0;
      o_vcnt  = 3'd0;
      o_chan  = 8'd0;
      o_ctype = 8'd0;
      o_port  = 16'd0;
      o_last  = 1'b0;
      case (cmd.emit)
         EMIT_PASS: begin
            o_word[0] = in_frame ? MARK : byte_ff;
            o_vcnt    = 3'd1;
            o_last    = 1'b1;
         end
         EMIT_INIT: begin
            o_kind = KIND_INIT;
         end
         EMIT_FRAME: begin
            o_chan = chan_ff;
            o_last = plast_ff;
            if (is_cmd_ff) begin
               o_kind  = KIND_CMD;
               o_ctype = ctype_ff;
               o_port  = port_ff;
            end else begin
               o_kind = KIND_DATA;
               o_word = word_ff;
               o_vcnt = vcnt_ff;
            end
         end
         default: begin
            o_kind = KIND_PASS;
         end
      endcase
      if (cmd.emit != EMIT_NONE) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff      <= 1'b1;
         done_ff      <= 1'b0;
         pos_ff       <= 5'd0;
         run_ff       <= 3'd0;
         count_ff     <= 8'd0;
         expected_ff  <= 8'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         role_ff      <= role_in;
         done_ff      <= done_in;
         pos_ff       <= pos_in;
         run_ff       <= run_in;
         count_ff     <= count_in;
         expected_ff  <= expected_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      l_ff      <= l_in;
      tail_ff   <= tail_in;
      is_cmd_ff <= is_cmd_in;
      bits_ff   <= bits_in;
      j_ff      <= j_in;
      chan_ff   <= chan_in;
      ctype_ff  <= ctype_in;
      port_ff   <= port_in;
      word_ff   <= word_in;
      vcnt_ff   <= vcnt_in;
      plast_ff  <= plast_in;
      if (cmd.emit != EMIT_NONE) begin
         kind_ff   <= o_kind;
         oword_ff  <= o_word;
         ovcnt_ff  <= o_vcnt;
         ochan_ff  <= o_chan;
         octype_ff <= o_ctype;
         oport_ff  <= o_port;
         olast_ff  <= o_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_byte0        = oword_ff[0];
   assign rsp_byte1        = oword_ff[1];
   assign rsp_byte2        = oword_ff[2];
   assign rsp_byte3        = oword_ff[3];
   assign rsp_valid_bytes  = ovcnt_ff;
   assign rsp_channel      = ochan_ff;
   assign rsp_command_type = octype_ff;
   assign rsp_port         = oport_ff;
   assign rsp_last         = olast_ff;

endmodule

### rtl/escaped_frame_stream_decoder.sv
`timescale 1ns / 1ps
// Top level of the escaped frame stream decoder: controller plus datapath.
// Depends on efsd_pkg, efsd_ctrl, efsd_dp (and efsd_ram through the datapath).
//
//   Channel | Direction | Handshake          | Beat carries
//   req     | in        | req_valid/stall    | one stream byte
//   rsp     | out       | rsp_valid/stall    | one result (pass byte, data word, command, init)
//   csr     | in        | csr_valid/ready    | the role_is_client register
//
// A byte that lands outside a frame, or inside a frame before its last byte,
// is accepted in ST_IDLE and then decoded in ST_DECODE. The byte that
// completes the init text also goes through ST_PASS, because its pass-through
// result follows the init event. The last byte of a frame goes on to ST_ALIGN
// to realign the tail bit stack, then to a store read (ST_READ) and a gather
// (ST_GATHER) for each unpacked byte, which is seven eighths of the payload
// rounded down, and to ST_EMIT for each result beat; a data frame that unpacks
// to fewer than two bytes skips the walk. Every state that loads the result
// register waits while a held result sits under rsp_stall.
// Reset is synchronous and active high; it clears the stream state and sets
// client role. The frame store is not cleared, as only entries written in
// the current frame are read. rsp_stall only holds the result register; the
// next byte is still taken while a result waits, but its decode waits until
// the register frees.
module escaped_frame_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_byte0,
   output logic [7:0]  rsp_byte1,
   output logic [7:0]  rsp_byte2,
   output logic [7:0]  rsp_byte3,
   output logic [2:0]  rsp_valid_bytes,
   output logic [7:0]  rsp_channel,
   output logic [7:0]  rsp_command_type,
   output logic [15:0] rsp_port,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_role_is_client
);
   import efsd_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // The register is a single flop, so a write always completes at once.
   assign csr_ready = 1'b1;

   efsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   efsd_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_in_byte        (req_in_byte),
      .csr_valid          (csr_valid && csr_ready),
      .csr_role_is_client (csr_role_is_client),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_byte0          (rsp_byte0),
      .rsp_byte1          (rsp_byte1),
      .rsp_byte2          (rsp_byte2),
      .rsp_byte3          (rsp_byte3),
      .rsp_valid_bytes    (rsp_valid_bytes),
      .rsp_channel        (rsp_channel),
      .rsp_command_type   (rsp_command_type),
      .rsp_port           (rsp_port),
      .rsp_last           (rsp_last)
   );

   // One byte is worked on at a time: an accepted beat closes the input.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a byte is still being decoded");

   // The init event is always followed by the pass-through of its byte.
   a_init_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_INIT) |-> !rsp_last)
      else $error("init event flagged as last result");

   // A data word carries between one and four bytes.
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DATA) |->
         (rsp_valid_bytes != 3'd0) && (rsp_valid_bytes <= 3'd4))
      else $error("data word with bad byte count");

endmodule
